/* src/sitpd_pkg.sv */
// ----------------------------------------------------------------------------
// sitpd_pkg
// Shared types and constants of the signed integer to padded decimal block.
// ----------------------------------------------------------------------------
package sitpd_pkg;

    // Field width limits: requested width saturates at the smaller of the two
    parameter int MaxWidth    = 32;
    parameter int ResultLimit = 32;
    parameter int CapWidth    = (MaxWidth < ResultLimit) ? MaxWidth : ResultLimit;

    // Binary to BCD conversion geometry
    parameter int MagBits   = 32;
    parameter int NumDigits = 10;
    parameter int BcdBits   = 4 * NumDigits;

    // ASCII codes, six bits wide
    parameter logic [5:0] ChBlank = 6'd32;
    parameter logic [5:0] ChMinus = 6'd45;
    parameter logic [5:0] ChZero  = 6'd48;

    // Controller states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_LEN  = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;   // capture a new word
        logic shift;  // one double-dabble step
        logic calc;   // work out text length and padding
        logic emit;   // put one character on the result ports
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic conv_done;  // current shift is the final one
        logic emit_last;  // current character is the final one
    } status_t;

endpackage

/* src/signed_int_to_padded_decimal.sv */
// ----------------------------------------------------------------------------
// signed_int_to_padded_decimal
// Signed 32-bit integer to blank-padded decimal ASCII, one character a cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Input word: value (signed) and field_width are taken at a rising edge
//   where start is high and busy is low. busy stays high until the final
//   character of that word has been put out.
//   Result words: one ASCII character per cycle on out_char, marked by
//   strobe; last is high with the final character. Characters come leftmost
//   first: blank padding up to the field width, a minus sign for negative
//   values, then the digits, most significant first.
//   Sequence: double-dabble conversion (one bit per cycle through the shared
//   add-3 BCD stage), a sizing state for the text, then N characters,
//   N = max(width, text length), 1 to 32. The first character follows the
//   conversion and sizing states; a new word may be accepted in the cycle
//   after the last character.
//   Widths above the limit saturate; the most negative value converts as
//   "-2147483648".
//   Reset clears the sequencer to idle; no character is pending afterwards.
//   The receiver cannot hold characters off: each is valid for one cycle.
// ----------------------------------------------------------------------------
module signed_int_to_padded_decimal
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] value,
    input  logic [5:0]  field_width,
    output logic        strobe,
    output logic [5:0]  out_char,
    output logic        last
);

    sitpd_pkg::cmd_t    cmd;
    sitpd_pkg::status_t status;
    logic               char_last;

    // sequencer
    sitpd_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // conversion and character datapath
    sitpd_dpath u_dpath
    (
        .clk         (clk),
        .cmd         (cmd),
        .value       (value),
        .field_width (field_width),
        .status      (status),
        .out_char    (out_char),
        .last        (char_last)
    );

    // characters are only presented while the sequencer is emitting
    assign strobe = cmd.emit;
    assign last   = cmd.emit & char_last;

    // a character only ever appears while a word is in flight
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("character strobed while idle");

    // last only marks a strobed character
    a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> strobe)
        else $error("last without strobe");

    // characters of one word are contiguous
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |=> strobe)
        else $error("gap inside a conversion");

    // after the final character the block is ready again
    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        last |=> !busy)
        else $error("busy held after final character");

endmodule

/* src/sitpd_ctrl.sv */
// ----------------------------------------------------------------------------
// sitpd_ctrl
// Sequencer: load, convert, size the text, then emit characters.
// ----------------------------------------------------------------------------
module sitpd_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  sitpd_pkg::status_t  status,
    output sitpd_pkg::cmd_t     cmd,
    output logic                busy
);

    sitpd_pkg::state_t state_reg;
    sitpd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sitpd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            sitpd_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = sitpd_pkg::ST_CONV;
                end
            end
            sitpd_pkg::ST_CONV:
            begin
                cmd.shift = 1'b1;
                if (status.conv_done)
                begin
                    state_next = sitpd_pkg::ST_LEN;
                end
            end
            sitpd_pkg::ST_LEN:
            begin
                cmd.calc   = 1'b1;
                state_next = sitpd_pkg::ST_EMIT;
            end
            sitpd_pkg::ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (status.emit_last)
                begin
                    state_next = sitpd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sitpd_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != sitpd_pkg::ST_IDLE);

endmodule

/* src/sitpd_dpath.sv */
// ----------------------------------------------------------------------------
// sitpd_dpath
// Magnitude, double-dabble BCD register, length logic and character select.
// ----------------------------------------------------------------------------
module sitpd_dpath
(
    input  logic                clk,
    input  sitpd_pkg::cmd_t     cmd,
    input  logic [31:0]         value,
    input  logic [5:0]          field_width,
    output sitpd_pkg::status_t  status,
    output logic [5:0]          out_char,
    output logic                last
);

    logic [sitpd_pkg::MagBits-1:0] mag_reg,   mag_next;
    logic [sitpd_pkg::BcdBits-1:0] bcd_reg,   bcd_next;
    logic [4:0]                    bit_reg,   bit_next;
    logic                          neg_reg,   neg_next;
    logic [5:0]                    width_reg, width_next;
    logic [5:0]                    total_reg, total_next;
    logic [5:0]                    pad_reg,   pad_next;
    logic [5:0]                    k_reg,     k_next;

    logic [sitpd_pkg::BcdBits-1:0] bcd_adj;
    logic [3:0]                    ndig;
    logic [3:0]                    textlen;
    logic [5:0]                    total_c;
    logic [5:0]                    dig_pos;
    logic [3:0]                    dig_val;

    // add-3 correction on every digit before the shift
    always_comb
    begin
        for (int d = 0; d < sitpd_pkg::NumDigits; d++)
        begin
            if (bcd_reg[4*d +: 4] >= 4'd5)
            begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
            end
        end
    end

    // digits in use: highest non-zero digit, at least one
    always_comb
    begin
        ndig = 4'd1;
        for (int d = 1; d < sitpd_pkg::NumDigits; d++)
        begin
            if (bcd_reg[4*d +: 4] != 4'd0)
            begin
                ndig = 4'(d + 1);
            end
        end
        textlen = ndig + {3'd0, neg_reg};
        total_c = (width_reg > {2'd0, textlen}) ? width_reg : {2'd0, textlen};
    end

    always_comb
    begin
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        bit_next   = bit_reg;
        neg_next   = neg_reg;
        width_next = width_reg;
        total_next = total_reg;
        pad_next   = pad_reg;
        k_next     = k_reg;
        if (cmd.load)
        begin
            neg_next = value[31];
            mag_next = value[31] ? (32'd0 - value) : value;
            bcd_next = '0;
            bit_next = '0;
            if (int'(field_width) > sitpd_pkg::CapWidth)
            begin
                width_next = 6'(sitpd_pkg::CapWidth);
            end
            else
            begin
                width_next = field_width;
            end
        end
        if (cmd.shift)
        begin
            {bcd_next, mag_next} = {bcd_adj[sitpd_pkg::BcdBits-2:0], mag_reg, 1'b0};
            bit_next = bit_reg + 5'd1;
        end
        if (cmd.calc)
        begin
            total_next = total_c;
            pad_next   = total_c - {2'd0, textlen};
            k_next     = '0;
        end
        if (cmd.emit)
        begin
            k_next = k_reg + 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        bcd_reg   <= bcd_next;
        bit_reg   <= bit_next;
        neg_reg   <= neg_next;
        width_reg <= width_next;
        total_reg <= total_next;
        pad_reg   <= pad_next;
        k_reg     <= k_next;
    end

    assign status.conv_done = (bit_reg == 5'(sitpd_pkg::MagBits - 1));
    assign status.emit_last = (k_reg == total_reg - 6'd1);

    // digit position counted from the least significant end
    assign dig_pos = total_reg - 6'd1 - k_reg;

    always_comb
    begin
        dig_val = 4'd0;
        for (int d = 0; d < sitpd_pkg::NumDigits; d++)
        begin
            if (dig_pos == 6'(d))
            begin
                dig_val = bcd_reg[4*d +: 4];
            end
        end
    end

    always_comb
    begin
        priority if (k_reg < pad_reg)
        begin
            out_char = sitpd_pkg::ChBlank;
        end
        else if (neg_reg && (k_reg == pad_reg))
        begin
            out_char = sitpd_pkg::ChMinus;
        end
        else
        begin
            out_char = sitpd_pkg::ChZero + {2'd0, dig_val};
        end
    end

    assign last = status.emit_last;

endmodule
